// ----- rtl/ulpsf_pkg.sv -----
package ulpsf_pkg;

    // store geometry, split into an even and an odd byte bank
    localparam int STORE_BYTES = 65536;
    localparam int BANK_DEPTH  = STORE_BYTES / 2;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int BANK_AW     = $clog2(BANK_DEPTH);

    // longest fetch run
    localparam int MAX_RUN = 64;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // configuration register indexes
    localparam logic CFG_ULAW_MODE   = 1'b0;
    localparam logic CFG_DATA_LENGTH = 1'b1;

    // g.711 mu-law bias
    localparam logic [15:0] ULAW_BIAS = 16'h0084;

    // g.711 mu-law byte to signed 16-bit linear
    function automatic logic [15:0] ulaw_expand(input logic [7:0] code);
        logic [7:0]  b;
        logic [2:0]  exponent;
        logic [3:0]  mantissa;
        logic [15:0] magnitude;
        b         = ~code;
        exponent  = b[6:4];
        mantissa  = b[3:0];
        magnitude = (({9'd0, mantissa, 3'd0} + ULAW_BIAS) << exponent) - ULAW_BIAS;
        if (b[7])
            ulaw_expand = 16'd0 - magnitude;
        else
            ulaw_expand = magnitude;
    endfunction

endpackage

// ----- rtl/ulaw_pcm_sample_fetch.sv -----
// channel   direction  ports
// -------   ---------  -----------------------------------------------------------
// item      in         start, busy, func, write_address, write_byte,
//                      record_offset, sample_offset, sample_count
// result    out        strobe, sample, is_padding, fetched_count, last
// config    in         cfg_write, cfg_index, cfg_data
//
// A write item stores its byte in the cycle it is taken and leaves busy low.
// A fetch item passes through a setup state, then reads one sample per cycle (1 to 64);
// store bytes sit in an even and an odd bank so both bytes of a PCM sample are read together.
// Each result passes the bank read register, then the output registers; one word per strobe.
// rst_n clears control state; store contents stay undefined until written.
// The receiver cannot stall: each word is shown for exactly one cycle.
module ulaw_pcm_sample_fetch (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic [15:0]         write_address,
    input  logic [7:0]          write_byte,
    input  logic [15:0]         record_offset,
    input  logic [15:0]         sample_offset,
    input  logic [6:0]          sample_count,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [16:0]         cfg_data,
    output logic                strobe,
    output logic signed [15:0]  sample,
    output logic                is_padding,
    output logic [6:0]          fetched_count,
    output logic                last
);
    import ulpsf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    state_t                state_reg, state_next;
    logic                  ulaw_mode_reg;
    logic [16:0]           data_length_reg;

    // run context
    logic                  mode_reg;
    logic [17:0]           start_reg;
    logic [6:0]            count_reg;
    logic [6:0]            got_reg, got_next;
    logic [6:0]            idx_reg;
    logic [17:0]           addr_reg;

    // read stage
    logic                  v1_reg, pad1_reg, last1_reg, lsb1_reg, mode1_reg;
    logic [6:0]            cnt1_reg;

    // output registers
    logic                  strobe_reg, pad_reg, last_reg;
    logic [15:0]           sample_reg, sample_next;
    logic [6:0]            fetched_reg;

    logic                  accept, wr;
    logic [17:0]           start_next;
    logic [6:0]            count_sat;
    logic [16:0]           limit, diff, avail;
    logic                  issue_pad, issue_last;
    logic                  bank_re;
    logic [BANK_AW-1:0]    even_raddr, odd_raddr;
    logic [7:0]            even_q, odd_q, ulaw_byte;

    assign accept = start && (state_reg == ST_IDLE);
    assign wr     = accept && (func == FUNC_WRITE);
    assign busy   = (state_reg != ST_IDLE);

    // fetch start byte and saturated count
    assign start_next = {2'd0, record_offset} +
                        (ulaw_mode_reg ? {2'd0, sample_offset} : {1'b0, sample_offset, 1'b0});
    assign count_sat  = (sample_count > 7'(MAX_RUN)) ? 7'(MAX_RUN) : sample_count;

    // real samples available in this run
    always_comb
    begin
        limit = (data_length_reg > 17'(STORE_BYTES)) ? 17'(STORE_BYTES) : data_length_reg;
        diff  = limit - start_reg[16:0];
        if ({1'b0, limit} > start_reg)
            avail = mode_reg ? diff : {1'b0, diff[16:1]};
        else
            avail = 17'd0;
        got_next = ({10'd0, count_reg} < avail) ? count_reg : avail[6:0];
    end

    // read issue for the current run position
    assign issue_pad  = (idx_reg >= got_reg);
    assign issue_last = (idx_reg + 7'd1 == count_reg);
    assign bank_re    = (state_reg == ST_RUN) && !issue_pad;
    assign odd_raddr  = addr_reg[ADDR_W-1:1];
    assign even_raddr = addr_reg[ADDR_W-1:1] + BANK_AW'(addr_reg[0]);

    ulpsf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even_bank (
        .clk   (clk),
        .we    (wr && !write_address[0]),
        .waddr (write_address[ADDR_W-1:1]),
        .wdata (write_byte),
        .re    (bank_re),
        .raddr (even_raddr),
        .rdata (even_q)
    );

    ulpsf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd_bank (
        .clk   (clk),
        .we    (wr && write_address[0]),
        .waddr (write_address[ADDR_W-1:1]),
        .wdata (write_byte),
        .re    (bank_re),
        .raddr (odd_raddr),
        .rdata (odd_q)
    );

    // decode the word that came back from the banks
    assign ulaw_byte = lsb1_reg ? odd_q : even_q;
    always_comb
    begin
        if (pad1_reg)
            sample_next = 16'd0;
        else if (mode1_reg)
            sample_next = ulaw_expand(ulaw_byte);
        else if (lsb1_reg)
            sample_next = {even_q, odd_q};
        else
            sample_next = {odd_q, even_q};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_FETCH) && (sample_count != 7'd0))
                    state_next = ST_SETUP;
            end
            ST_SETUP:
                state_next = ST_RUN;
            ST_RUN:
            begin
                if (issue_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state, run context, pipeline and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ulaw_mode_reg   <= 1'b1;
            data_length_reg <= 17'd0;
            mode_reg        <= 1'b1;
            start_reg       <= 18'd0;
            count_reg       <= 7'd0;
            got_reg         <= 7'd0;
            idx_reg         <= 7'd0;
            addr_reg        <= 18'd0;
            v1_reg          <= 1'b0;
            pad1_reg        <= 1'b0;
            last1_reg       <= 1'b0;
            lsb1_reg        <= 1'b0;
            mode1_reg       <= 1'b0;
            cnt1_reg        <= 7'd0;
            strobe_reg      <= 1'b0;
            pad_reg         <= 1'b0;
            last_reg        <= 1'b0;
            sample_reg      <= 16'd0;
            fetched_reg     <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ULAW_MODE:   ulaw_mode_reg   <= cfg_data[0];
                    CFG_DATA_LENGTH: data_length_reg <= cfg_data;
                    default:         ;
                endcase
            end

            // latch a fetch
            if (accept && (func == FUNC_FETCH))
            begin
                mode_reg  <= ulaw_mode_reg;
                start_reg <= start_next;
                count_reg <= count_sat;
            end

            // setup: real sample count and first address
            if (state_reg == ST_SETUP)
            begin
                got_reg  <= got_next;
                idx_reg  <= 7'd0;
                addr_reg <= start_reg;
            end

            // walk the run one sample a cycle
            if (state_reg == ST_RUN)
            begin
                idx_reg  <= idx_reg + 7'd1;
                addr_reg <= addr_reg + (mode_reg ? 18'd1 : 18'd2);
            end

            // read stage bookkeeping
            v1_reg    <= (state_reg == ST_RUN);
            pad1_reg  <= issue_pad;
            last1_reg <= issue_last;
            cnt1_reg  <= issue_last ? got_reg : 7'd0;
            lsb1_reg  <= addr_reg[0];
            mode1_reg <= mode_reg;

            // output word
            strobe_reg  <= v1_reg;
            pad_reg     <= v1_reg && pad1_reg;
            last_reg    <= v1_reg && last1_reg;
            fetched_reg <= v1_reg ? cnt1_reg : 7'd0;
            sample_reg  <= v1_reg ? sample_next : 16'd0;
        end
    end

    assign strobe        = strobe_reg;
    assign sample        = sample_reg;
    assign is_padding    = pad_reg;
    assign fetched_count = fetched_reg;
    assign last          = last_reg;

endmodule

// ----- rtl/ulpsf_ram.sv -----
module ulpsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule
